>>> sv/nmea_rmc_position_parser_assert.svh
// assertion macros used by the nmea rmc position parser top level
`ifndef NMEA_RMC_POSITION_PARSER_ASSERT_SVH
`define NMEA_RMC_POSITION_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define NRMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nrmc assertion failed");
// next-cycle implication
`define NRMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nrmc assertion failed");
`else
`define NRMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define NRMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/nrmc_pkg.sv
// types, constants and helper functions of the nmea rmc position parser
package nrmc_pkg;

	localparam int unsigned FRAC_DIGITS = 5;
	localparam int unsigned TOKEN_LIMIT = 13;

	localparam int unsigned FRAC_SCALE = 10 ** FRAC_DIGITS;
	localparam int unsigned FRAC_W     = $clog2(FRAC_SCALE);
	localparam int unsigned FCNT_W     = $clog2(FRAC_DIGITS + 1);
	localparam int unsigned MIN_SCALE  = 10 ** (7 - FRAC_DIGITS);
	localparam int unsigned MIN_W      = $clog2(100 * FRAC_SCALE);

	localparam int unsigned CHAR_W = 8;
	localparam int unsigned INT_W  = 20;
	localparam int unsigned UTC_W  = 18;
	localparam int unsigned CC_W   = 4;
	localparam int unsigned SKIP_W = 3;
	localparam int unsigned LAT_W  = 31;
	localparam int unsigned LON_W  = 32;
	localparam int unsigned MAG_W  = 31;
	localparam int unsigned Q_W    = 14;
	localparam int unsigned REM_W  = 7;
	localparam int unsigned DEG_W  = 38;
	localparam int unsigned X_W    = 30;
	localparam int unsigned MQ_W   = 24;

	// reciprocal for integer part / 100, exact below 2^20
	localparam int unsigned RECIP100_SHIFT = 27;
	localparam int unsigned RECIP100_W     = 21;
	localparam int unsigned Q100_PROD_W    = INT_W + RECIP100_W;
	localparam logic [RECIP100_W-1:0] RECIP100 = 21'd1342178;

	// reciprocal for (x >> 2) / 15, exact below 2^28
	localparam int unsigned RECIP15_SHIFT = 32;
	localparam int unsigned RECIP15_W     = 29;
	localparam int unsigned Q60_PROD_W    = X_W - 2 + RECIP15_W;
	localparam logic [RECIP15_W-1:0] RECIP15 = 29'd286331154;

	localparam logic [INT_W-1:0] INT_SAT   = 20'd999999;
	localparam logic [INT_W-1:0] INT_GUARD = 20'd100000;
	localparam logic [UTC_W-1:0] UTC_MAX   = 18'd235959;
	localparam logic [MAG_W-1:0] LAT_MAX   = 31'd900000000;
	localparam logic [MAG_W-1:0] LON_MAX   = 31'd1800000000;
	localparam logic [23:0]      DEG_SCALE = 24'd10000000;
	localparam logic [X_W-1:0]   ROUND_HALF = 30'd30;

	localparam logic [SKIP_W-1:0] SKIP_RESET = 3'd2;

	localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_SOUTH = 8'h53;
	localparam logic [CHAR_W-1:0] CH_WEST  = 8'h57;

	// field indexes after the prefix
	localparam logic [CC_W-1:0] FLD_UTC     = 4'd0;
	localparam logic [CC_W-1:0] FLD_STATUS  = 4'd1;
	localparam logic [CC_W-1:0] FLD_LAT     = 4'd2;
	localparam logic [CC_W-1:0] FLD_LAT_HEM = 4'd3;
	localparam logic [CC_W-1:0] FLD_LON     = 4'd4;
	localparam logic [CC_W-1:0] FLD_LON_HEM = 4'd5;
	localparam logic [CC_W-1:0] FLD_MODE    = 4'd11;
	localparam logic [CC_W-1:0] FLD_LAST    = CC_W'(TOKEN_LIMIT - 1);

	// fields that travel with every item through the back end
	typedef struct packed {
		logic              conv;
		logic              is_lon;
		logic              finish;
		logic [UTC_W-1:0]  utc;
		logic [CHAR_W-1:0] fix;
		logic [CHAR_W-1:0] mode;
		logic              lat_neg;
		logic              lon_neg;
	} tag_t;

	// one queued job from the front end
	typedef struct packed {
		tag_t              tag;
		logic [INT_W-1:0]  int_part;
		logic [FRAC_W-1:0] frac;
		logic [FCNT_W-1:0] frac_cnt;
	} job_t;

	// 10^n for the fraction padding, n up to FRAC_DIGITS
	function automatic logic [FRAC_W-1:0] pow10_frac(input logic [FCNT_W-1:0] n);
		logic [FRAC_W-1:0] p;
		p = FRAC_W'(1);
		for (int i = 0; i < FRAC_DIGITS; i++) begin
			if (FCNT_W'(i) < n) begin
				p = FRAC_W'(p * FRAC_W'(10));
			end
		end
		return p;
	endfunction

endpackage

>>> sv/nmea_rmc_position_parser.sv
// path from the accepted last character to out_valid: queue, 6 stages, result reg
// throughput: one character per cycle; the input stalls only while the job queue is full
// the queue fills only while a result waits on out_stall, which freezes the conversion pipeline
// reset: async active low, clears parse state, queue and pipeline, skip_commas returns to 2
// no clearing pass after reset, the block takes characters on the first cycle
module nmea_rmc_position_parser #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration: skip_commas
	input  logic                                cfg_wr_en,
	input  logic [nrmc_pkg::SKIP_W-1:0]         cfg_wr_data,
	// character input
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [nrmc_pkg::CHAR_W-1:0]         char_in,
	input  logic                                last_char,
	// result output
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [nrmc_pkg::UTC_W-1:0]          utc_time,
	output logic [nrmc_pkg::CHAR_W-1:0]         fix_status,
	output logic [nrmc_pkg::CHAR_W-1:0]         mode_char,
	output logic signed [nrmc_pkg::LAT_W-1:0]   latitude,
	output logic signed [nrmc_pkg::LON_W-1:0]   longitude
);

`include "nmea_rmc_position_parser_assert.svh"

	// front to queue
	logic           q_push;
	nrmc_pkg::job_t q_push_job;
	logic           q_full;
	// queue to back
	logic           q_pop;
	nrmc_pkg::job_t q_pop_job;
	logic           q_empty;

	logic           in_acc;

	// the front only needs a free queue slot, never the back end itself
	assign in_stall = q_full;
	assign in_acc   = in_valid && !in_stall;

	// front: prefix skip, field split, digit accumulation, emits a job per
	// closed lat/lon field and per last character
	nrmc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.q_full      (q_full),
		.char_in     (char_in),
		.last_char   (last_char),
		.push        (q_push),
		.push_job    (q_push_job)
	);

	// decouples the character rate from the conversion pipeline stalls
	nrmc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_push_job),
		.pop      (q_pop),
		.pop_job  (q_pop_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	// back: in-order six stage conversion, lat/lon holding regs, result reg
	nrmc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.pop_job    (q_pop_job),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.utc_time   (utc_time),
		.fix_status (fix_status),
		.mode_char  (mode_char),
		.latitude   (latitude),
		.longitude  (longitude)
	);

	// queue never written while full nor read while empty
	`NRMC_ASSERT_IMP(a_q_no_overflow, clk, arst_n, q_push, !q_full)
	`NRMC_ASSERT_IMP(a_q_no_underflow, clk, arst_n, q_pop, !q_empty)
	// a final character always leaves a job behind in the queue
	`NRMC_ASSERT_NEXT(a_last_queued, clk, arst_n, in_acc && last_char, !q_empty)
	// clamping keeps both coordinates in range
	`NRMC_ASSERT_IMP(a_coord_range, clk, arst_n, out_valid, (latitude <= 31'sd900000000) && (latitude >= -31'sd900000000) && (longitude <= 32'sd1800000000) && (longitude >= -32'sd1800000000))

endmodule

>>> sv/nrmc_fifo.sv
// short job queue between the parser front end and the conversion back end
module nrmc_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  nrmc_pkg::job_t push_job,
	input  logic           pop,
	output nrmc_pkg::job_t pop_job,
	output logic           full,
	output logic           empty
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	nrmc_pkg::job_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

>>> sv/nrmc_front.sv
// character front end: prefix skip, field split, digit accumulation, job issue
module nrmc_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [nrmc_pkg::SKIP_W-1:0]     cfg_wr_data,
	input  logic                            in_valid,
	input  logic                            q_full,
	input  logic [nrmc_pkg::CHAR_W-1:0]     char_in,
	input  logic                            last_char,
	output logic                            push,
	output nrmc_pkg::job_t                  push_job
);

	logic [nrmc_pkg::SKIP_W-1:0] skip_q;
	logic [nrmc_pkg::SKIP_W-1:0] pfx_q, pfx_d;
	logic [nrmc_pkg::CC_W-1:0]   cc_q, cc_d;
	logic                        start_q, start_d;
	logic                        point_q, point_d;
	logic [nrmc_pkg::INT_W-1:0]  int_q, int_d;
	logic [nrmc_pkg::FRAC_W-1:0] frac_q, frac_d;
	logic [nrmc_pkg::FCNT_W-1:0] fcnt_q, fcnt_d;
	logic [nrmc_pkg::UTC_W-1:0]  utc_q, utc_d;
	logic [nrmc_pkg::CHAR_W-1:0] fix_q, fix_d;
	logic [nrmc_pkg::CHAR_W-1:0] mode_q, mode_d;
	logic                        lat_neg_q, lat_neg_d;
	logic                        lon_neg_q, lon_neg_d;

	logic                        acc;
	logic                        is_comma;
	logic                        is_digit;
	logic                        hem_neg;
	logic                        comma_close;
	logic                        last_close;
	logic [3:0]                  digit;
	logic [23:0]                 int_step;

	function automatic logic [nrmc_pkg::UTC_W-1:0] utc_sat(input logic [nrmc_pkg::INT_W-1:0] v);
		return (v > nrmc_pkg::INT_W'(nrmc_pkg::UTC_MAX)) ? nrmc_pkg::UTC_MAX
			: v[nrmc_pkg::UTC_W-1:0];
	endfunction

	assign acc      = in_valid && !q_full;
	assign is_comma = (char_in == nrmc_pkg::CH_COMMA);
	assign is_digit = (char_in >= nrmc_pkg::CH_ZERO) && (char_in <= nrmc_pkg::CH_NINE);
	assign hem_neg  = (char_in == nrmc_pkg::CH_SOUTH) || (char_in == nrmc_pkg::CH_WEST);
	assign digit    = char_in[3:0];
	assign int_step = {int_q, 3'b000} + {3'b000, int_q, 1'b0} + 24'(digit);

	always_comb begin
		pfx_d       = pfx_q;
		cc_d        = cc_q;
		start_d     = start_q;
		point_d     = point_q;
		int_d       = int_q;
		frac_d      = frac_q;
		fcnt_d      = fcnt_q;
		utc_d       = utc_q;
		fix_d       = fix_q;
		mode_d      = mode_q;
		lat_neg_d   = lat_neg_q;
		lon_neg_d   = lon_neg_q;
		comma_close = 1'b0;

		priority if (pfx_q < skip_q) begin
			if (is_comma) begin
				pfx_d = pfx_q + nrmc_pkg::SKIP_W'(1);
			end
		end else if (is_comma && (cc_q < nrmc_pkg::FLD_LAST)) begin
			comma_close = 1'b1;
			if (cc_q == nrmc_pkg::FLD_UTC) begin
				utc_d = utc_sat(int_q);
			end
			start_d = 1'b1;
			point_d = 1'b0;
			int_d   = '0;
			frac_d  = '0;
			fcnt_d  = '0;
			cc_d    = cc_q + nrmc_pkg::CC_W'(1);
		end else begin
			if (start_q) begin
				priority if (cc_q == nrmc_pkg::FLD_STATUS) begin
					fix_d = char_in;
				end else if (cc_q == nrmc_pkg::FLD_LAT_HEM) begin
					lat_neg_d = hem_neg;
				end else if (cc_q == nrmc_pkg::FLD_LON_HEM) begin
					lon_neg_d = hem_neg;
				end else if (cc_q == nrmc_pkg::FLD_MODE) begin
					mode_d = char_in;
				end
				start_d = 1'b0;
			end
			priority if ((char_in == nrmc_pkg::CH_POINT) && !point_q) begin
				point_d = 1'b1;
			end else if (is_digit) begin
				priority if (!point_q) begin
					// saturating integer part
					if ((int_q >= nrmc_pkg::INT_GUARD) || (int_step > 24'(nrmc_pkg::INT_SAT))) begin
						int_d = nrmc_pkg::INT_SAT;
					end else begin
						int_d = int_step[nrmc_pkg::INT_W-1:0];
					end
				end else if (fcnt_q < nrmc_pkg::FCNT_W'(nrmc_pkg::FRAC_DIGITS)) begin
					frac_d = nrmc_pkg::FRAC_W'(frac_q * nrmc_pkg::FRAC_W'(10))
						+ nrmc_pkg::FRAC_W'(digit);
					fcnt_d = fcnt_q + nrmc_pkg::FCNT_W'(1);
				end
			end
		end

		// the last character closes the open field unless still inside the prefix
		last_close = last_char && !(pfx_d < skip_q);
		if (last_close && (cc_d == nrmc_pkg::FLD_UTC)) begin
			utc_d = utc_sat(int_d);
		end
	end

	// job classification
	always_comb begin
		push_job.int_part     = int_q;
		push_job.frac         = frac_q;
		push_job.frac_cnt     = fcnt_q;
		push_job.tag.conv     = 1'b0;
		push_job.tag.is_lon   = 1'b0;
		push_job.tag.finish   = last_char;
		push_job.tag.utc      = utc_d;
		push_job.tag.fix      = fix_d;
		push_job.tag.mode     = mode_d;
		push_job.tag.lat_neg  = lat_neg_d;
		push_job.tag.lon_neg  = lon_neg_d;
		priority if (comma_close && ((cc_q == nrmc_pkg::FLD_LAT) || (cc_q == nrmc_pkg::FLD_LON))) begin
			push_job.tag.conv   = 1'b1;
			push_job.tag.is_lon = (cc_q == nrmc_pkg::FLD_LON);
		end else if (!comma_close && last_close
			&& ((cc_d == nrmc_pkg::FLD_LAT) || (cc_d == nrmc_pkg::FLD_LON))) begin
			push_job.tag.conv   = 1'b1;
			push_job.tag.is_lon = (cc_d == nrmc_pkg::FLD_LON);
			push_job.int_part   = int_d;
			push_job.frac       = frac_d;
			push_job.frac_cnt   = fcnt_d;
		end
	end

	assign push = acc && (push_job.tag.conv || last_char);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= nrmc_pkg::SKIP_RESET;
		end else if (cfg_wr_en) begin
			skip_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pfx_q     <= '0;
			cc_q      <= '0;
			start_q   <= 1'b1;
			point_q   <= 1'b0;
			int_q     <= '0;
			frac_q    <= '0;
			fcnt_q    <= '0;
			utc_q     <= '0;
			fix_q     <= '0;
			mode_q    <= '0;
			lat_neg_q <= 1'b0;
			lon_neg_q <= 1'b0;
		end else if (acc) begin
			if (last_char) begin
				pfx_q     <= '0;
				cc_q      <= '0;
				start_q   <= 1'b1;
				point_q   <= 1'b0;
				int_q     <= '0;
				frac_q    <= '0;
				fcnt_q    <= '0;
				utc_q     <= '0;
				fix_q     <= '0;
				mode_q    <= '0;
				lat_neg_q <= 1'b0;
				lon_neg_q <= 1'b0;
			end else begin
				pfx_q     <= pfx_d;
				cc_q      <= cc_d;
				start_q   <= start_d;
				point_q   <= point_d;
				int_q     <= int_d;
				frac_q    <= frac_d;
				fcnt_q    <= fcnt_d;
				utc_q     <= utc_d;
				fix_q     <= fix_d;
				mode_q    <= mode_d;
				lat_neg_q <= lat_neg_d;
				lon_neg_q <= lon_neg_d;
			end
		end
	end

endmodule

>>> sv/nrmc_back.sv
// conversion back end: ddmm.mmmmm to 1e-7 degree pipeline and result register
module nrmc_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_empty,
	input  nrmc_pkg::job_t                      pop_job,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [nrmc_pkg::UTC_W-1:0]          utc_time,
	output logic [nrmc_pkg::CHAR_W-1:0]         fix_status,
	output logic [nrmc_pkg::CHAR_W-1:0]         mode_char,
	output logic signed [nrmc_pkg::LAT_W-1:0]   latitude,
	output logic signed [nrmc_pkg::LON_W-1:0]   longitude
);

	logic adv;
	logic retire;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	nrmc_pkg::tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6;

	logic [nrmc_pkg::INT_W-1:0]  int_s1;
	logic [nrmc_pkg::Q_W-1:0]    q_s1;
	logic [nrmc_pkg::FRAC_W-1:0] fpad_s1, fpad_s2;
	logic [nrmc_pkg::REM_W-1:0]  rem_s2;
	logic [nrmc_pkg::DEG_W-1:0]  degp_s2, degp_s3, degp_s4, degp_s5;
	logic [nrmc_pkg::MIN_W-1:0]  m_s3;
	logic [nrmc_pkg::X_W-1:0]    x_s4;
	logic [nrmc_pkg::MQ_W-1:0]   mq_s5;
	logic [nrmc_pkg::MAG_W-1:0]  mag_s6;

	logic [nrmc_pkg::LAT_W-2:0]  lat_mag_q, lat_sel;
	logic [nrmc_pkg::LON_W-2:0]  lon_mag_q, lon_sel;
	logic                        out_valid_q;
	logic [nrmc_pkg::UTC_W-1:0]  utc_q;
	logic [nrmc_pkg::CHAR_W-1:0] fix_q;
	logic [nrmc_pkg::CHAR_W-1:0] mode_q;
	logic [nrmc_pkg::LAT_W-1:0]  lat_q;
	logic [nrmc_pkg::LON_W-1:0]  lon_q;

	logic [nrmc_pkg::Q100_PROD_W-1:0] q100_prod;
	logic [nrmc_pkg::FCNT_W-1:0]      pad;
	logic [nrmc_pkg::INT_W-1:0]       q_x100;
	logic [nrmc_pkg::Q60_PROD_W-1:0]  q60_prod;
	logic [nrmc_pkg::DEG_W-1:0]       sum_s5;
	logic [nrmc_pkg::MAG_W-1:0]       limit_s5;

	// whole pipeline moves together; it only holds while a result waits
	assign adv    = !out_valid_q || !out_stall;
	assign pop    = adv && !q_empty;
	assign retire = adv && v_s6;

	// stage 1: degrees by reciprocal of 100, fraction padded to full digits
	assign q100_prod = nrmc_pkg::Q100_PROD_W'(pop_job.int_part)
		* nrmc_pkg::Q100_PROD_W'(nrmc_pkg::RECIP100);
	assign pad = nrmc_pkg::FCNT_W'(nrmc_pkg::FRAC_DIGITS) - pop_job.frac_cnt;

	// stage 2: whole minutes and degree part
	assign q_x100 = nrmc_pkg::INT_W'(q_s1) * nrmc_pkg::INT_W'(100);

	// stage 5: minutes / 60 as (x >> 2) / 15
	assign q60_prod = nrmc_pkg::Q60_PROD_W'(x_s4[nrmc_pkg::X_W-1:2])
		* nrmc_pkg::Q60_PROD_W'(nrmc_pkg::RECIP15);

	// stage 6 input: degrees plus rounded minutes, clamped per axis
	assign sum_s5   = degp_s5 + nrmc_pkg::DEG_W'(mq_s5);
	assign limit_s5 = tag_s5.is_lon ? nrmc_pkg::LON_MAX : nrmc_pkg::LAT_MAX;

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1  <= pop_job.tag;
			int_s1  <= pop_job.int_part;
			q_s1    <= q100_prod[nrmc_pkg::RECIP100_SHIFT +: nrmc_pkg::Q_W];
			fpad_s1 <= nrmc_pkg::FRAC_W'(pop_job.frac * nrmc_pkg::pow10_frac(pad));

			tag_s2  <= tag_s1;
			rem_s2  <= nrmc_pkg::REM_W'(int_s1 - q_x100);
			degp_s2 <= nrmc_pkg::DEG_W'(q_s1) * nrmc_pkg::DEG_W'(nrmc_pkg::DEG_SCALE);
			fpad_s2 <= fpad_s1;

			tag_s3  <= tag_s2;
			m_s3    <= nrmc_pkg::MIN_W'(rem_s2) * nrmc_pkg::MIN_W'(nrmc_pkg::FRAC_SCALE)
				+ nrmc_pkg::MIN_W'(fpad_s2);
			degp_s3 <= degp_s2;

			tag_s4  <= tag_s3;
			x_s4    <= nrmc_pkg::X_W'(m_s3) * nrmc_pkg::X_W'(nrmc_pkg::MIN_SCALE)
				+ nrmc_pkg::ROUND_HALF;
			degp_s4 <= degp_s3;

			tag_s5  <= tag_s4;
			mq_s5   <= q60_prod[nrmc_pkg::RECIP15_SHIFT +: nrmc_pkg::MQ_W];
			degp_s5 <= degp_s4;

			tag_s6  <= tag_s5;
			mag_s6  <= (sum_s5 > nrmc_pkg::DEG_W'(limit_s5)) ? limit_s5
				: sum_s5[nrmc_pkg::MAG_W-1:0];
		end
	end

	// a job that converts and finishes at once uses its fresh magnitude
	assign lat_sel = (tag_s6.conv && !tag_s6.is_lon) ? mag_s6[nrmc_pkg::LAT_W-2:0] : lat_mag_q;
	assign lon_sel = (tag_s6.conv && tag_s6.is_lon) ? mag_s6[nrmc_pkg::LON_W-2:0] : lon_mag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			out_valid_q <= 1'b0;
			lat_mag_q   <= '0;
			lon_mag_q   <= '0;
		end else begin
			if (adv) begin
				v_s1 <= pop;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
				v_s5 <= v_s4;
				v_s6 <= v_s5;
			end
			if (retire && tag_s6.finish) begin
				lat_mag_q   <= '0;
				lon_mag_q   <= '0;
				out_valid_q <= 1'b1;
			end else begin
				if (retire && tag_s6.conv) begin
					if (tag_s6.is_lon) begin
						lon_mag_q <= lon_sel;
					end else begin
						lat_mag_q <= lat_sel;
					end
				end
				if (!out_stall) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (retire && tag_s6.finish) begin
			utc_q  <= tag_s6.utc;
			fix_q  <= tag_s6.fix;
			mode_q <= tag_s6.mode;
			lat_q  <= tag_s6.lat_neg ? (nrmc_pkg::LAT_W'(0) - nrmc_pkg::LAT_W'(lat_sel))
				: nrmc_pkg::LAT_W'(lat_sel);
			lon_q  <= tag_s6.lon_neg ? (nrmc_pkg::LON_W'(0) - nrmc_pkg::LON_W'(lon_sel))
				: nrmc_pkg::LON_W'(lon_sel);
		end
	end

	assign out_valid  = out_valid_q;
	assign utc_time   = utc_q;
	assign fix_status = fix_q;
	assign mode_char  = mode_q;
	assign latitude   = $signed(lat_q);
	assign longitude  = $signed(lon_q);

endmodule

>>> bench/nmea_rmc_position_parser_tb.sv
// self-checking bench for the nmea rmc position parser: directed responses, a back-pressure burst, then random ones
`timescale 1ns / 100ps

module nmea_rmc_position_parser_tb;
	import nrmc_pkg::*;

	// one parsed fix as it leaves the block
	typedef struct packed {
		logic [UTC_W-1:0]         utc;
		logic [CHAR_W-1:0]        fix;
		logic [CHAR_W-1:0]        mode;
		logic signed [LAT_W-1:0]  lat;
		logic signed [LON_W-1:0]  lon;
	} rmc_fix_t;

	// one directed response, with the fix typed in where it is obvious
	typedef struct {
		int       skip_set;
		string    text;
		bit       typed;
		rmc_fix_t want;
	} probe_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_wr_en = 1'b0;
	logic [SKIP_W-1:0]         cfg_wr_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [CHAR_W-1:0]         char_in = '0;
	logic                      last_char = 1'b0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [UTC_W-1:0]          utc_time;
	logic [CHAR_W-1:0]         fix_status;
	logic [CHAR_W-1:0]         mode_char;
	logic signed [LAT_W-1:0]   latitude;
	logic signed [LON_W-1:0]   longitude;

	// fixes the parser owes us, oldest first
	rmc_fix_t     fixes_due[$];
	probe_t       probes[$];
	logic [7:0]   sentence[$];
	int unsigned  fault_count = 0;
	int unsigned  chars_sent = 0;
	int unsigned  fixes_predicted = 0;
	int unsigned  send_gap_pct = 0;
	int unsigned  recv_stall_pct = 0;
	int unsigned  holds_asked = 0;
	int unsigned  holds_done = 0;
	int unsigned  hold_left = 0;
	bit           use_typed = 1'b0;
	rmc_fix_t     typed_fix;

	// parser state mirrored at the block's widths
	logic [SKIP_W-1:0]  skip_reg;
	logic [SKIP_W-1:0]  prefix_cnt;
	logic [CC_W-1:0]    field_idx;
	bit                 fld_start;
	bit                 seen_point;
	logic [INT_W-1:0]   int_acc;
	logic [16:0]        frac_acc;
	logic [2:0]         frac_cnt;
	logic [UTC_W-1:0]   held_utc;
	logic [CHAR_W-1:0]  held_fix;
	logic [CHAR_W-1:0]  held_mode;
	logic [29:0]        lat_mag;
	logic [CHAR_W-1:0]  lat_hem;
	logic [30:0]        lon_mag;
	logic [CHAR_W-1:0]  lon_hem;

	nmea_rmc_position_parser DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.char_in     (char_in),
		.last_char   (last_char),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.utc_time    (utc_time),
		.fix_status  (fix_status),
		.mode_char   (mode_char),
		.latitude    (latitude),
		.longitude   (longitude)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic void restart_field();
		fld_start = 1'b1;
		seen_point = 1'b0;
		int_acc = '0;
		frac_acc = '0;
		frac_cnt = '0;
	endfunction

	function automatic void restart_sentence();
		prefix_cnt = '0;
		field_idx = '0;
		restart_field();
		held_utc = '0;
		held_fix = '0;
		held_mode = '0;
		lat_mag = '0;
		lat_hem = '0;
		lon_mag = '0;
		lon_hem = '0;
	endfunction

	// ddmm.mmmmm to degrees * 1e7, minutes / 60 rounded half up, clamped to limit
	function automatic logic [MAG_W-1:0] field_deg7(input longint unsigned limit);
		longint unsigned scale, padded, ip, minutes, mag;
		scale = 1;
		repeat (FRAC_DIGITS) scale = scale * 10;
		padded = frac_acc;
		for (int unsigned k = frac_cnt; k < FRAC_DIGITS; k++) padded = padded * 10;
		ip = int_acc;
		minutes = (ip % 100) * scale + padded;
		mag = (ip / 100) * DEG_SCALE + (minutes * DEG_SCALE + 30 * scale) / (60 * scale);
		if (mag > limit) begin
			mag = limit;
		end
		return MAG_W'(mag);
	endfunction

	function automatic void finish_field();
		if (field_idx == FLD_UTC) begin
			held_utc = (int_acc > UTC_MAX) ? UTC_MAX : UTC_W'(int_acc);
		end else if (field_idx == FLD_LAT) begin
			lat_mag = 30'(field_deg7(LAT_MAX));
		end else if (field_idx == FLD_LON) begin
			lon_mag = 31'(field_deg7(LON_MAX));
		end
		restart_field();
	endfunction

	function automatic logic [31:0] signed_deg7(input logic [31:0] mag, input logic [7:0] hem);
		return (hem == CH_SOUTH || hem == CH_WEST) ? -mag : mag;
	endfunction

	// advance the mirror by one character; returns 1 when a fix comes out
	function automatic bit fix_step(input logic [7:0] c, input bit fin, output rmc_fix_t fix);
		int unsigned d, grown;
		if (prefix_cnt < skip_reg) begin
			if (c == CH_COMMA) begin
				prefix_cnt = prefix_cnt + 1'b1;
			end
		end else if (c == CH_COMMA && field_idx < FLD_LAST) begin
			finish_field();
			field_idx = field_idx + 1'b1;
		end else begin
			if (fld_start) begin
				case (field_idx)
					FLD_STATUS:  held_fix = c;
					FLD_LAT_HEM: lat_hem = c;
					FLD_LON_HEM: lon_hem = c;
					FLD_MODE:    held_mode = c;
					default: ;
				endcase
				fld_start = 1'b0;
			end
			if (c == CH_POINT && !seen_point) begin
				seen_point = 1'b1;
			end else if (c >= CH_ZERO && c <= CH_NINE) begin
				d = c - CH_ZERO;
				if (!seen_point) begin
					grown = int_acc * 10 + d;
					int_acc = (int_acc >= INT_GUARD || grown > INT_SAT) ? INT_SAT : INT_W'(grown);
				end else if (frac_cnt < FRAC_DIGITS) begin
					frac_acc = frac_acc * 10 + d;
					frac_cnt = frac_cnt + 1'b1;
				end
			end
		end
		if (!fin) begin
			return 1'b0;
		end
		if (prefix_cnt >= skip_reg) begin
			finish_field();
		end
		fix.utc = held_utc;
		fix.fix = held_fix;
		fix.mode = held_mode;
		fix.lat = LAT_W'(signed_deg7(32'(lat_mag), lat_hem));
		fix.lon = signed_deg7(32'(lon_mag), lon_hem);
		restart_sentence();
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------- response builders

	function automatic void add_digits(input int unsigned n);
		repeat (n) sentence.push_back(8'(CH_ZERO + $urandom_range(9)));
	endfunction

	// mostly one of two expected letters, sometimes empty or any byte
	function automatic void add_letter(input logic [7:0] lead, input logic [7:0] alt);
		int unsigned pick;
		pick = $urandom_range(9);
		if (pick < 4) begin
			sentence.push_back(lead);
		end else if (pick < 8) begin
			sentence.push_back(alt);
		end else if (pick == 9) begin
			sentence.push_back(8'($urandom_range(255)));
		end
	endfunction

	// ddmm.mmmmm style number, now and then empty, short, long or without a point
	function automatic void add_coordinate(input int unsigned int_len);
		if ($urandom_range(9) == 0) begin
			return;
		end
		add_digits($urandom_range(7) == 0 ? $urandom_range(1, 7) : int_len);
		if ($urandom_range(4) != 0) begin
			sentence.push_back(CH_POINT);
			add_digits($urandom_range(7));
		end
	endfunction

	function automatic void build_noise(input int unsigned max_len);
		sentence.delete();
		repeat ($urandom_range(1, max_len)) begin
			sentence.push_back($urandom_range(3) == 0 ? CH_COMMA : 8'($urandom_range(255)));
		end
	endfunction

	// mostly well-formed responses, some cut short, some plain noise
	function automatic void build_random();
		int unsigned pick, keep;
		pick = $urandom_range(99);
		if (pick >= 85) begin
			build_noise(12);
			return;
		end
		sentence.delete();
		for (int i = 0; i < skip_reg; i++) begin
			repeat ($urandom_range(3)) sentence.push_back(8'($urandom_range(8'h5A, 8'h41)));
			sentence.push_back(CH_COMMA);
		end
		if ($urandom_range(9) != 0) begin
			add_digits($urandom_range(9) == 0 ? $urandom_range(9, 7) : 6);
			if ($urandom_range(1) != 0) begin
				sentence.push_back(CH_POINT);
				add_digits($urandom_range(3, 1));
			end
		end
		sentence.push_back(CH_COMMA);
		add_letter("A", "V");
		sentence.push_back(CH_COMMA);
		add_coordinate(4);
		sentence.push_back(CH_COMMA);
		add_letter("N", "S");
		sentence.push_back(CH_COMMA);
		add_coordinate(5);
		sentence.push_back(CH_COMMA);
		add_letter("E", "W");
		// speed, course, date, variation and its direction
		repeat (5) begin
			sentence.push_back(CH_COMMA);
			add_digits($urandom_range(3));
		end
		sentence.push_back(CH_COMMA);
		add_letter("A", "D");
		// trailing fields run past the field limit
		if ($urandom_range(4) == 0) begin
			repeat ($urandom_range(4, 1)) begin
				sentence.push_back(CH_COMMA);
				add_digits($urandom_range(2));
			end
		end
		if ($urandom_range(7) == 0) begin
			sentence.insert($urandom_range(sentence.size() - 1), 8'($urandom_range(255)));
		end
		if (pick >= 70) begin
			keep = $urandom_range(sentence.size(), 1);
			while (sentence.size() > keep) void'(sentence.pop_back());
		end
	endfunction

	// ---------------------------------------------------------------- drivers

	task automatic send_char(input logic [7:0] c, input bit fin);
		rmc_fix_t fix;
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		char_in <= c;
		last_char <= fin;
		do @(posedge clk); while (in_stall);
		chars_sent++;
		if (fix_step(c, fin, fix)) begin
			fixes_due.push_back(use_typed ? typed_fix : fix);
			fixes_predicted++;
		end
	endtask

	task automatic send_sentence();
		foreach (sentence[i]) send_char(sentence[i], i == sentence.size() - 1);
	endtask

	// every owed fix in, then the pipeline latency so a trailing partial item settles
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (fixes_due.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_skip(input logic [SKIP_W-1:0] v);
		wait_drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		skip_reg = v;
	endtask

	function automatic void add_probe(input int skip_set, input string text, input bit typed,
		input logic [UTC_W-1:0] utc = '0, input logic [7:0] fix = '0,
		input logic [7:0] mode = '0, input int lat = 0, input int lon = 0);
		probe_t row;
		row.skip_set = skip_set;
		row.text = text;
		row.typed = typed;
		row.want = {utc, fix, mode, LAT_W'(lat), LON_W'(lon)};
		probes.push_back(row);
	endfunction

	// ---------------------------------------------------------------- result side

	// checks each accepted fix and picks the next stall, with the long hold-off on request
	always @(posedge clk) begin : fix_monitor
		rmc_fix_t seen, want;
		if (arst_n && out_valid && !out_stall) begin
			seen = {utc_time, fix_status, mode_char, latitude, longitude};
			if (fixes_due.size() == 0) begin
				fault_count++;
				if (fault_count <= 10) begin
					$display("%0t: fix with none due: utc %0d fix %h mode %h lat %0d lon %0d",
						$time, seen.utc, seen.fix, seen.mode, $signed(seen.lat), $signed(seen.lon));
				end
			end else begin
				want = fixes_due.pop_front();
				if (seen.utc !== want.utc || seen.fix !== want.fix || seen.mode !== want.mode ||
					seen.lat !== want.lat || seen.lon !== want.lon) begin
					fault_count++;
					if (fault_count <= 10) begin
						$display("%0t: fix mismatch, expected utc %0d fix %h mode %h lat %0d lon %0d",
							$time, want.utc, want.fix, want.mode, $signed(want.lat),
							$signed(want.lon));
						$display("%0t: fix mismatch, actual   utc %0d fix %h mode %h lat %0d lon %0d",
							$time, seen.utc, seen.fix, seen.mode, $signed(seen.lat),
							$signed(seen.lon));
					end
				end
			end
		end
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (holds_done != holds_asked) begin
			out_stall <= 1'b1;
			hold_left <= 250;
			holds_done <= holds_done + 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// ---------------------------------------------------------------- stimulus

	initial begin : stimulus
		int unsigned seg_chars, seg_fixes;
		skip_reg = SKIP_RESET;
		restart_sentence();

		// reset state: a response that ends inside the prefix gives all zeros
		add_probe(-1, ",", 1'b1);
		// ordinary response behind a two-comma prefix
		add_probe(-1, "+RMC:1,2,123519.00,A,4807.03800,N,01131.00000,E,0.1,0.0,230394,3.1,W,A",
			1'b0);
		// saturated integer part, clamped utc and coordinates, both negated
		add_probe(0, "9999999,V,9999.99999,S,99999.99999,W,,,,,,N", 1'b1,
			UTC_MAX, "V", "N", -900000000, -1800000000);
		// zeros and an empty status field
		add_probe(-1, "000000,,0000.00000,N,00000.00000,E", 1'b1);
		// minutes rounding, short fraction padded
		add_probe(-1, "1,A,0000.00003,N,00000.5,E,,,,,,D", 1'b0);
		// no point, commas past the field limit
		add_probe(-1, "123,A,4530,N,1,2,3,4,5,6,7,M,8,9,10,,,,", 1'b0);
		// junk in numbers, a second point, extra fraction digits
		add_probe(-1, "12a3.4.5,A,12x34.567890123,S,-0123.4,W", 1'b0);
		// longest prefix, response ends before it is through
		add_probe(7, "a,b,c,d,e,f,123456", 1'b1);
		add_probe(-1, "p,,,,,,,654321,A", 1'b0);
		// empty numbers with a negating hemisphere stay zero
		add_probe(3, "1,2,3,,A,,S,,W", 1'b0);
		add_probe(2, "$GNRMC,x,235960.5,A,9000.00000,N,18000.00000,E,,,,,,A", 1'b0);

		send_gap_pct = 20;
		recv_stall_pct = 75;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probes[i]) begin
			if (probes[i].skip_set >= 0) begin
				write_skip(SKIP_W'(probes[i].skip_set));
			end
			use_typed = probes[i].typed;
			typed_fix = probes[i].want;
			sentence.delete();
			for (int k = 0; k < probes[i].text.len(); k++) sentence.push_back(probes[i].text[k]);
			send_sentence();
		end
		use_typed = 1'b0;

		// result side holds off while short responses pile up and back-pressure the input
		wait_drain();
		send_gap_pct = 0;
		recv_stall_pct = 0;
		holds_asked++;
		repeat (40) begin
			build_noise(3);
			send_sentence();
		end

		// random part: three idling regimes, prefix length cycling through its extremes, its reset value and a random one
		for (int seg = 0; seg < 12; seg++) begin
			case (seg / 4)
				0: begin
					send_gap_pct = 20;
					recv_stall_pct = 75;
				end
				1: begin
					send_gap_pct = 75;
					recv_stall_pct = 20;
				end
				default: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			case (seg % 4)
				0: write_skip(3'd0);
				1: write_skip(3'd7);
				2: write_skip(SKIP_RESET);
				default: write_skip(SKIP_W'($urandom_range(7)));
			endcase
			seg_chars = chars_sent;
			seg_fixes = fixes_predicted;
			while (chars_sent - seg_chars < 90 || fixes_predicted - seg_fixes < 4) begin
				build_random();
				send_sentence();
			end
		end

		wait_drain();
		if (fault_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// watchdog far beyond the slowest correct run
	initial begin
		#4000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
